### design/bdsq_pkg.sv
`default_nettype none

package bdsq_pkg;

	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd45;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-cycle shift commands, all zero when no item is taken
	typedef struct packed {
		logic push_first;
		logic push_second;
		logic pop_first;
		logic pop_second;
	} shift_ctl_t;

endpackage

`default_nettype wire

### design/bdsq_cell.sv
`default_nettype none

module bdsq_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  bdsq_pkg::shift_ctl_t        ctl,
	input  wire                         hit_first,
	input  wire                         hit_second,
	input  wire [bdsq_pkg::CHAR_W-1:0]  push_char,
	input  wire [bdsq_pkg::CHAR_W-1:0]  next_first,
	input  wire [bdsq_pkg::CHAR_W-1:0]  next_second,
	output logic [bdsq_pkg::CHAR_W-1:0] first_q,
	output logic [bdsq_pkg::CHAR_W-1:0] second_q
);
	import bdsq_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= BLANK_CHAR;
		end else if (ctl.pop_first) begin
			first_q <= next_first;
		end else if (ctl.push_first && hit_first) begin
			first_q <= push_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= BLANK_CHAR;
		end else if (ctl.pop_second) begin
			second_q <= next_second;
		end else if (ctl.push_second && hit_second) begin
			second_q <= push_char;
		end
	end

endmodule

`default_nettype wire

### design/bdsq_ctrl.sv
`default_nettype none

module bdsq_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	parameter int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  take,
	input  wire                  opcode,
	output bdsq_pkg::shift_ctl_t ctl,
	output bdsq_pkg::status_t    status,
	output logic [FILL_W-1:0]    first_fill_q,
	output logic [FILL_W-1:0]    second_fill_q,
	output logic [FILL_W-1:0]    first_fill_d,
	output logic [FILL_W-1:0]    second_fill_d
);
	import bdsq_pkg::*;

	localparam logic [FILL_W-1:0] DEPTH = FILL_W'(QUEUE_DEPTH);

	always_comb begin
		ctl    = '0;
		status = ST_DONE;
		if (opcode == OP_PUSH) begin
			if (first_fill_q <= second_fill_q) begin
				if (first_fill_q < DEPTH) begin
					ctl.push_first = take;
				end else begin
					status = ST_FULL;
				end
			end else begin
				// second is shorter here, so it always has room
				ctl.push_second = take;
			end
		end else begin
			if (first_fill_q == '0 && second_fill_q == '0) begin
				status = ST_EMPTY;
			end else if (first_fill_q >= second_fill_q) begin
				ctl.pop_first = take;
			end else begin
				ctl.pop_second = take;
			end
		end
	end

	always_comb begin
		first_fill_d  = first_fill_q;
		second_fill_d = second_fill_q;
		if (ctl.push_first)  first_fill_d  = first_fill_q + 1'b1;
		if (ctl.pop_first)   first_fill_d  = first_fill_q - 1'b1;
		if (ctl.push_second) second_fill_d = second_fill_q + 1'b1;
		if (ctl.pop_second)  second_fill_d = second_fill_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_fill_q  <= '0;
			second_fill_q <= '0;
		end else begin
			first_fill_q  <= first_fill_d;
			second_fill_q <= second_fill_d;
		end
	end

endmodule

`default_nettype wire

### design/balanced_dual_shift_queue.sv
// Pair of byte queues built as a row of shift cells, kept balanced.
// Input stream (s_tvalid/s_tready/s_tdata): one command per item, push a
// byte or pop from the longer queue. Output stream (m_tvalid/m_tready/
// m_tdata): exactly one result per command, with the popped byte, a status
// and both fill counts after the command.
// A push lands in the first queue when its count is at most the second's,
// else in the second; a full first queue on that path means both are full
// and the byte is dropped with status full. A pop shifts every cell of the
// chosen queue one place forward at once; the tail takes '-'.
// The command updates the cells and counts at the accepting edge, and the
// result is loaded into the output register at that same edge.
// Throughput is one item per cycle while the receiver keeps m_tready high.
// s_tready is high while the output register is empty or being emptied,
// so a stalled receiver holds the result and blocks only further input.
// Reset clears both counts and loads '-' into every cell; no clearing pass.
`default_nettype none

module balanced_dual_shift_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // [0] opcode, [8:1] push_char, [15:9] zero
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata   // [7:0] popped_char, [9:8] status,
	                              // [14:10] first_count, [19:15] second_count
);
	import bdsq_pkg::*;

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic                take;
	logic                opcode;
	logic [CHAR_W-1:0]   push_char;
	shift_ctl_t          ctl;
	status_t             status;
	logic [FILL_W-1:0]   first_fill_q;
	logic [FILL_W-1:0]   second_fill_q;
	logic [FILL_W-1:0]   first_fill_d;
	logic [FILL_W-1:0]   second_fill_d;
	logic [CHAR_W-1:0]   first_slot  [QUEUE_DEPTH];
	logic [CHAR_W-1:0]   second_slot [QUEUE_DEPTH];
	logic [CHAR_W-1:0]   popped_char;
	logic                out_valid_q;
	logic [23:0]         out_data_q;

	assign opcode    = s_tdata[0];
	assign push_char = s_tdata[8:1];
	assign s_tready  = !out_valid_q || m_tready;
	assign take      = s_tvalid && s_tready;

	bdsq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.FILL_W      (FILL_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.opcode        (opcode),
		.ctl           (ctl),
		.status        (status),
		.first_fill_q  (first_fill_q),
		.second_fill_q (second_fill_q),
		.first_fill_d  (first_fill_d),
		.second_fill_d (second_fill_d)
	);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [CHAR_W-1:0] next_first;
		logic [CHAR_W-1:0] next_second;

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_first  = BLANK_CHAR;
			assign next_second = BLANK_CHAR;
		end else begin : g_body
			assign next_first  = first_slot[i+1];
			assign next_second = second_slot[i+1];
		end

		bdsq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.hit_first   (first_fill_q == FILL_W'(i)),
			.hit_second  (second_fill_q == FILL_W'(i)),
			.push_char   (push_char),
			.next_first  (next_first),
			.next_second (next_second),
			.first_q     (first_slot[i]),
			.second_q    (second_slot[i])
		);
	end

	always_comb begin
		popped_char = BLANK_CHAR;
		if (ctl.pop_first) begin
			popped_char = first_slot[0];
		end else if (ctl.pop_second) begin
			popped_char = second_slot[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= {4'd0, COUNT_W'(second_fill_d), COUNT_W'(first_fill_d),
				status, popped_char};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

### design/bdsq_checker.sv
`default_nettype none

module bdsq_assertions (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);
	import bdsq_pkg::*;

	logic [COUNT_W-1:0] first_cnt;
	logic [COUNT_W-1:0] second_cnt;
	logic [STAT_W-1:0]  stat;

	assign stat       = m_tdata[9:8];
	assign first_cnt  = m_tdata[14:10];
	assign second_cnt = m_tdata[19:15];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the two counts never differ by more than one; a tie pop leaves the first shorter
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (first_cnt == second_cnt) ||
			(first_cnt == COUNT_W'(second_cnt + 1'b1)) ||
			(second_cnt == COUNT_W'(first_cnt + 1'b1)))
		else $error("queues out of balance");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && stat == ST_EMPTY |-> first_cnt == '0 && second_cnt == '0)
		else $error("empty status with stored entries");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (stat == ST_FULL || stat == ST_EMPTY) |-> m_tdata[7:0] == BLANK_CHAR)
		else $error("non-blank byte on failed command");

	// an accepted item always yields a result on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item gave no result");

endmodule

bind balanced_dual_shift_queue bdsq_assertions u_bdsq_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
